[hdl/fpba_pkg.sv]
package fpba_pkg;

    // Default sizes of the block store.
    localparam int DEF_NUM_BLOCKS = 16;
    localparam int DEF_SIZE_BITS  = 16;

    // Fixed widths of the interface fields.
    localparam int CMD_W     = 1;
    localparam int IDX_W     = 4;
    localparam int AMT_W     = 16;
    localparam int POL_W     = 2;
    localparam int BLK_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

    // Placement policies. The unused code behaves as first fit.
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;

    // Configuration reset values.
    localparam logic [POL_W-1:0] POLICY_RESET = POL_FIRST;
    localparam logic [BLK_W-1:0] BLOCKS_RESET = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the input item and restart the scan
        logic issue;      // read the next block during the scan
        logic load_wr;    // store a load item and present its result
        logic alloc_fin;  // write back the chosen block and present the result
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // every searched block has been read
    } t_dp_stat;

endpackage

[hdl/fit_policy_block_allocator.sv]
// Channel    Direction  Handshake               Payload
// command    in         i_start, o_busy         i_command, i_block_index, i_amount
// result     out        o_done strobe           o_granted, o_chosen_block, o_space_left
// config     in         i_cfg_valid, o_cfg_ready i_cfg_index, i_cfg_data
//
// A command transfers when i_start is high and o_busy is low. A load stores its
// item in the load state and its result is registered from there. An allocate reads
// the searched blocks one per cycle through the single read port of the block store,
// then passes the drain and done states before its result is registered.
// Reset clears the configuration to first fit over sixteen blocks and marks every
// block empty. The result strobe lasts one cycle and cannot be stalled.
module fit_policy_block_allocator
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [IDX_W-1:0]     i_block_index,
    input  logic [AMT_W-1:0]     i_amount,
    output logic                 o_done,
    output logic                 o_granted,
    output logic [IDX_W-1:0]     o_chosen_block,
    output logic [AMT_W-1:0]     o_space_left,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int LW = $clog2(NUM_BLOCKS + 1);

    logic [POL_W-1:0] r_policy;
    logic [BLK_W-1:0] r_blocks;
    logic [LW-1:0]    w_limit;
    t_ctl_cmd         w_cmd;
    t_dp_stat         w_stat;

    // The configuration port never pushes back; writes to unknown indexes
    // are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POLICY_RESET;
            r_blocks <= BLOCKS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_FIT_POLICY) begin
                r_policy <= i_cfg_data[POL_W-1:0];
            end else if (i_cfg_index == REG_BLOCKS_IN_USE) begin
                r_blocks <= i_cfg_data[BLK_W-1:0];
            end
        end
    end

    // A search count above the store size is clamped to the store size.
    always_comb begin
        if (32'(r_blocks) > NUM_BLOCKS) begin
            w_limit = LW'(NUM_BLOCKS);
        end else begin
            w_limit = LW'(r_blocks);
        end
    end

    fpba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_command (i_command),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_busy    (o_busy)
    );

    fpba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .LW         (LW)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_policy       (r_policy),
        .i_limit        (w_limit),
        .i_block_index  (i_block_index),
        .i_amount       (i_amount),
        .o_done         (o_done),
        .o_granted      (o_granted),
        .o_chosen_block (o_chosen_block),
        .o_space_left   (o_space_left)
    );

    // A result only follows a busy period, and the block is free again when
    // the result is shown.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(o_busy) && !o_busy))
        else $error("result strobe without a preceding busy period");

    // An accepted command makes the block busy in the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted command did not raise busy");

    // A refused request reports block zero with no space.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_granted) |-> (o_chosen_block == '0 && o_space_left == '0))
        else $error("refused result carries nonzero fields");

endmodule

[hdl/fpba_ctrl.sv]
module fpba_ctrl
    import fpba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [CMD_W-1:0]     i_command,
    input  t_dp_stat             i_stat,
    output t_ctl_cmd             o_cmd,
    output logic                 o_busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_command == CMD_ALLOC) ? S_SCAN : S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            S_DRAIN: begin
                // The last read word was judged in the previous cycle; this
                // cycle only spaces out the write back.
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.alloc_fin = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[hdl/fpba_datapath.sv]
module fpba_datapath
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = DEF_SIZE_BITS,
    parameter int LW         = $clog2(NUM_BLOCKS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl_cmd             i_cmd,
    output t_dp_stat             o_stat,
    input  logic [POL_W-1:0]     i_policy,
    input  logic [LW-1:0]        i_limit,
    input  logic [IDX_W-1:0]     i_block_index,
    input  logic [AMT_W-1:0]     i_amount,
    output logic                 o_done,
    output logic                 o_granted,
    output logic [IDX_W-1:0]     o_chosen_block,
    output logic [AMT_W-1:0]     o_space_left
);

    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

    // Block store with one write port and one registered read port.
    logic [SIZE_BITS-1:0]  r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_valid;

    logic [IDX_W-1:0]      r_idx;
    logic [AMT_W-1:0]      r_amt;
    logic [LW-1:0]         r_cnt;
    logic [SIZE_BITS-1:0]  r_rd_data;
    logic                  r_rd_ok;
    logic                  r_eval_vld;
    logic [IW-1:0]         r_eval_idx;
    logic                  r_found;
    logic [IW-1:0]         r_pick;
    logic [SIZE_BITS-1:0]  r_best;
    logic                  r_done;
    logic                  r_granted;
    logic [IDX_W-1:0]      r_chosen;
    logic [AMT_W-1:0]      r_left;

    logic [IW-1:0]         w_rd_addr;
    logic [IW-1:0]         w_ld_addr;
    logic                  w_ld_in_range;
    logic [SIZE_BITS-1:0]  w_ld_value;
    logic [SIZE_BITS-1:0]  w_size;
    logic                  w_fits;
    logic                  w_take;
    logic [SIZE_BITS-1:0]  w_remain;
    logic                  w_wr_en;
    logic [IW-1:0]         w_wr_addr;
    logic [SIZE_BITS-1:0]  w_wr_data;

    assign w_rd_addr     = r_cnt[IW-1:0];
    assign w_ld_addr     = IW'(r_idx);
    assign w_ld_in_range = (32'(r_idx) < NUM_BLOCKS);
    assign w_ld_value    = SIZE_BITS'(r_amt);
    assign w_size        = r_rd_ok ? r_rd_data : '0;
    assign w_fits        = (CW'(w_size) >= CW'(r_amt));
    assign w_remain      = SIZE_BITS'(CW'(r_best) - CW'(r_amt));

    assign o_stat.scan_done = (r_cnt == i_limit);

    // A candidate replaces the current pick according to the policy.
    always_comb begin
        w_take = 1'b0;
        if (r_eval_vld && w_fits) begin
            priority if (!r_found) begin
                w_take = 1'b1;
            end else if (i_policy == POL_BEST) begin
                w_take = (w_size < r_best);
            end else if (i_policy == POL_WORST) begin
                w_take = (w_size > r_best);
            end else begin
                w_take = 1'b0;
            end
        end
    end

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_ld_addr;
        w_wr_data = w_ld_value;
        if (i_cmd.load_wr && w_ld_in_range) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.alloc_fin && r_found) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_pick;
            w_wr_data = w_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_ok   <= r_valid[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_cnt      <= '0;
            r_eval_vld <= 1'b0;
            r_found    <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
            r_eval_vld <= i_cmd.issue;
            r_done     <= i_cmd.load_wr | i_cmd.alloc_fin;
            if (i_cmd.capture) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.issue) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (w_take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx <= i_block_index;
            r_amt <= i_amount;
        end
        if (i_cmd.issue) begin
            r_eval_idx <= w_rd_addr;
        end
        if (w_take) begin
            r_pick <= r_eval_idx;
            r_best <= w_size;
        end
        if (i_cmd.load_wr) begin
            r_granted <= w_ld_in_range;
            r_chosen  <= w_ld_in_range ? r_idx : '0;
            r_left    <= w_ld_in_range ? AMT_W'(w_ld_value) : '0;
        end else if (i_cmd.alloc_fin) begin
            r_granted <= r_found;
            r_chosen  <= r_found ? IDX_W'(r_pick) : '0;
            r_left    <= r_found ? AMT_W'(w_remain) : '0;
        end
    end

    assign o_done         = r_done;
    assign o_granted      = r_granted;
    assign o_chosen_block = r_chosen;
    assign o_space_left   = r_left;

endmodule

[tb/fit_policy_block_allocator_tb.sv]
`timescale 1ns / 100ps

module fit_policy_block_allocator_tb;
    import fpba_pkg::*;

    localparam int NBLK = DEF_NUM_BLOCKS;

    // The package names three policies. The fourth code is left unused and
    // must behave as first fit.
    localparam logic [POL_W-1:0] POL_SPARE = 2'd3;

    // An allocate takes at most sixteen block reads, and the sender idles with at
    // most 82 percent odds per cycle. The limit lies far above the longest quiet
    // stretch of any correct run.
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] blk;
        logic [AMT_W-1:0] left;
    } t_outcome;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CMD_W-1:0]     cmd;
        logic [IDX_W-1:0]     idx;
        logic [AMT_W-1:0]     amt;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DAT_W-1:0] reg_data;
        bit                   typed;
        t_outcome             want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic [CMD_W-1:0]     i_command = '0;
    logic [IDX_W-1:0]     i_block_index = '0;
    logic [AMT_W-1:0]     i_amount = '0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 o_busy;
    logic                 o_done;
    logic                 o_granted;
    logic [IDX_W-1:0]     o_chosen_block;
    logic [AMT_W-1:0]     o_space_left;
    logic                 o_cfg_ready;

    fit_policy_block_allocator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_command      (i_command),
        .i_block_index  (i_block_index),
        .i_amount       (i_amount),
        .o_done         (o_done),
        .o_granted      (o_granted),
        .o_chosen_block (o_chosen_block),
        .o_space_left   (o_space_left),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the block store and the two configuration registers.
    // They change only when a command or a register write transfers.
    logic [AMT_W-1:0] free_words [NBLK];
    logic [POL_W-1:0] cur_policy;
    logic [BLK_W-1:0] cur_blocks;

    // Outcomes still owed by the block, oldest first.
    t_outcome replies_due [$];
    t_row     plan [$];

    int idle_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;
    int n_loads = 0;
    int n_allocs = 0;
    int n_granted = 0;
    int n_regs = 0;

    // Applies one command to the shadow store and returns the outcome that
    // the block must report for it.
    function automatic t_outcome apply_command(input logic [CMD_W-1:0] cmd,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [AMT_W-1:0] amt);
        t_outcome res;
        int       lim;
        int       pick;
        bit       found;
        res = '0;
        if (cmd == CMD_LOAD) begin
            // The index field cannot reach past the store, so every load lands.
            free_words[idx] = amt;
            res = '{1'b1, idx, amt};
            return res;
        end
        // A search count above the store size saturates to the store size.
        lim = (cur_blocks > NBLK) ? NBLK : int'(cur_blocks);
        found = 1'b0;
        pick = 0;
        for (int b = 0; b < lim; b++) begin
            if (free_words[b] < amt) continue;
            if (!found) begin
                found = 1'b1;
                pick = b;
                if (cur_policy != POL_BEST && cur_policy != POL_WORST) break;
            end else if (cur_policy == POL_BEST && free_words[b] < free_words[pick]) begin
                pick = b;
            end else if (cur_policy == POL_WORST && free_words[b] > free_words[pick]) begin
                pick = b;
            end
        end
        if (found) begin
            free_words[pick] = free_words[pick] - amt;
            res = '{1'b1, IDX_W'(pick), free_words[pick]};
        end
        return res;
    endfunction

    function automatic t_row item_row(input logic [CMD_W-1:0] cmd,
                                      input logic [IDX_W-1:0] idx,
                                      input logic [AMT_W-1:0] amt);
        t_row r;
        r = '{kind: ROW_ITEM, cmd: cmd, idx: idx, amt: amt, reg_idx: '0,
              reg_data: '0, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic t_row item_row_exp(input logic [CMD_W-1:0] cmd,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [AMT_W-1:0] amt,
                                          input logic g,
                                          input logic [IDX_W-1:0] blk,
                                          input logic [AMT_W-1:0] left);
        t_row r;
        r = item_row(cmd, idx, amt);
        r.typed = 1'b1;
        r.want = '{g, blk, left};
        return r;
    endfunction

    function automatic t_row reg_row(input logic [CFG_IDX_W-1:0] ri,
                                     input logic [CFG_DAT_W-1:0] rd);
        t_row r;
        r = '{kind: ROW_REG, cmd: '0, idx: '0, amt: '0, reg_idx: ri,
              reg_data: rd, typed: 1'b0, want: '0};
        return r;
    endfunction

    // Presents one command, possibly after some idle cycles, and holds it
    // until it transfers. Entered and left just after a falling edge, so
    // every input change lands at a falling edge.
    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [IDX_W-1:0] idx,
                             input logic [AMT_W-1:0] amt,
                             input bit typed,
                             input t_outcome want);
        t_outcome calc;
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start       <= 1'b1;
        i_command     <= cmd;
        i_block_index <= idx;
        i_amount      <= amt;
        do @(posedge i_clk); while (o_busy);
        // The transfer happened at this edge; the store changes now.
        calc = apply_command(cmd, idx, amt);
        replies_due.push_back(typed ? want : calc);
        if (cmd == CMD_LOAD) begin
            n_loads++;
        end else begin
            n_allocs++;
            if (calc.granted) n_granted++;
        end
        @(negedge i_clk);
    endtask

    // Writes one register once every outstanding result has come back. Each
    // command yields exactly one result, so an empty queue means idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] ri,
                             input logic [CFG_DAT_W-1:0] rd);
        i_start <= 1'b0;
        while (replies_due.size() != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ri;
        i_cfg_data  <= rd;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (ri == REG_FIT_POLICY) begin
            cur_policy = rd[POL_W-1:0];
        end else if (ri == REG_BLOCKS_IN_USE) begin
            cur_blocks = rd;
        end
        n_regs++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Draws a random command. Loads mostly target blocks that are searched,
    // and sizes stay small so that most requests find a block. Some loads
    // copy another block's size to create ties, and some requests match a
    // stored size exactly to empty a block.
    task automatic random_item(output logic [CMD_W-1:0] cmd,
                               output logic [IDX_W-1:0] idx,
                               output logic [AMT_W-1:0] amt);
        int roll;
        int span;
        span = (cur_blocks == 0) ? 1 : ((cur_blocks > NBLK) ? NBLK : int'(cur_blocks));
        idx = IDX_W'($urandom());
        roll = $urandom_range(99);
        if (roll < 40) begin
            cmd = CMD_LOAD;
            if ($urandom_range(99) < 75) idx = IDX_W'($urandom_range(span - 1));
            roll = $urandom_range(99);
            if (roll < 5)       amt = '1;
            else if (roll < 10) amt = '0;
            else if (roll < 20) amt = free_words[IDX_W'($urandom_range(NBLK - 1))];
            else if (roll < 35) amt = AMT_W'($urandom());
            else                amt = AMT_W'($urandom_range(1023));
        end else begin
            cmd = CMD_ALLOC;
            roll = $urandom_range(99);
            if (roll < 8)       amt = '0;
            else if (roll < 12) amt = '1;
            else if (roll < 27) amt = free_words[IDX_W'($urandom_range(span - 1))];
            else if (roll < 37) amt = AMT_W'($urandom());
            else                amt = AMT_W'($urandom_range(300));
        end
    endtask

    // Each result strobe is compared with the oldest outcome still owed.
    always @(posedge i_clk) begin
        t_outcome exp_o;
        if (i_rst_n && o_done) begin
            if (replies_due.size() == 0) begin
                $display("%0t: result with none owed: granted %0d, block %0d, left %0d",
                         $time, o_granted, o_chosen_block, o_space_left);
                errors++;
            end else begin
                exp_o = replies_due.pop_front();
                if (o_granted !== exp_o.granted) begin
                    $display("%0t: granted expected %0d, got %0d",
                             $time, exp_o.granted, o_granted);
                    errors++;
                end
                if (o_chosen_block !== exp_o.blk) begin
                    $display("%0t: chosen_block expected %0d, got %0d",
                             $time, exp_o.blk, o_chosen_block);
                    errors++;
                end
                if (o_space_left !== exp_o.left) begin
                    $display("%0t: space_left expected %0d, got %0d",
                             $time, exp_o.left, o_space_left);
                    errors++;
                end
            end
        end
    end

    // Counts cycles in which no command, result or register write transfers.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("fit_policy_block_allocator: mismatch");
                $finish;
            end
        end
    end

    initial begin
        logic [CMD_W-1:0]     cmd;
        logic [IDX_W-1:0]     idx;
        logic [AMT_W-1:0]     amt;
        logic [CFG_DAT_W-1:0] blocks;
        int                   ph;
        int                   n;

        foreach (free_words[b]) free_words[b] = '0;
        cur_policy = POLICY_RESET;
        cur_blocks = BLOCKS_RESET;

        // Directed part. Expectations are typed in where they are obvious;
        // the remaining rows rely on the shadow store.
        // Right after reset every block is empty, so a zero request still
        // fits block zero and any nonzero request fails.
        plan.push_back(item_row_exp(CMD_ALLOC, 4'd0, 16'd0, 1'b1, 4'd0, 16'd0));
        plan.push_back(item_row_exp(CMD_ALLOC, 4'd0, 16'd1, 1'b0, 4'd0, 16'd0));
        plan.push_back(item_row_exp(CMD_LOAD, 4'd0, 16'hFFFF, 1'b1, 4'd0, 16'hFFFF));
        plan.push_back(item_row_exp(CMD_LOAD, 4'd15, 16'd100, 1'b1, 4'd15, 16'd100));
        plan.push_back(item_row(CMD_LOAD, 4'd5, 16'd300));
        plan.push_back(item_row(CMD_LOAD, 4'd3, 16'd200));
        // The largest request drains block zero; the index field is ignored.
        plan.push_back(item_row_exp(CMD_ALLOC, 4'd15, 16'hFFFF, 1'b1, 4'd0, 16'd0));
        plan.push_back(item_row(CMD_ALLOC, 4'd0, 16'd150));
        plan.push_back(reg_row(REG_FIT_POLICY, CFG_DAT_W'(POL_BEST)));
        plan.push_back(item_row(CMD_ALLOC, 4'd0, 16'd40));
        plan.push_back(item_row(CMD_LOAD, 4'd7, 16'd100));
        // Two blocks of equal size fit exactly; the lower index must win.
        plan.push_back(item_row(CMD_ALLOC, 4'd0, 16'd100));
        plan.push_back(reg_row(REG_FIT_POLICY, CFG_DAT_W'(POL_WORST)));
        plan.push_back(item_row(CMD_ALLOC, 4'd0, 16'd10));
        plan.push_back(item_row(CMD_LOAD, 4'd9, 16'd290));
        plan.push_back(item_row(CMD_ALLOC, 4'd0, 16'd1));
        // Narrow the search to four blocks: large blocks above it are skipped.
        plan.push_back(reg_row(REG_BLOCKS_IN_USE, 5'd4));
        plan.push_back(item_row_exp(CMD_ALLOC, 4'd0, 16'd20, 1'b0, 4'd0, 16'd0));
        plan.push_back(item_row(CMD_LOAD, 4'd2, 16'd60));
        // A load above the search count is stored but not searched.
        plan.push_back(item_row(CMD_LOAD, 4'd12, 16'd500));
        plan.push_back(item_row_exp(CMD_ALLOC, 4'd0, 16'd400, 1'b0, 4'd0, 16'd0));
        plan.push_back(item_row(CMD_ALLOC, 4'd0, 16'd5));
        // With no block searched, even a zero request is refused.
        plan.push_back(reg_row(REG_BLOCKS_IN_USE, 5'd0));
        plan.push_back(item_row_exp(CMD_ALLOC, 4'd0, 16'd0, 1'b0, 4'd0, 16'd0));
        // A count beyond the store saturates, which brings block 12 back.
        plan.push_back(reg_row(REG_BLOCKS_IN_USE, 5'd31));
        plan.push_back(item_row(CMD_ALLOC, 4'd0, 16'd1));
        plan.push_back(reg_row(REG_FIT_POLICY, CFG_DAT_W'(POL_SPARE)));
        plan.push_back(item_row(CMD_ALLOC, 4'd0, 16'd1));
        plan.push_back(reg_row(REG_BLOCKS_IN_USE, 5'd1));
        plan.push_back(item_row_exp(CMD_ALLOC, 4'd0, 16'd0, 1'b1, 4'd0, 16'd0));
        plan.push_back(item_row_exp(CMD_LOAD, 4'd15, 16'd0, 1'b1, 4'd15, 16'd0));

        // Synchronous reset is held from the start and released at a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_REG) begin
                write_reg(plan[k].reg_idx, plan[k].reg_data);
            end else begin
                send_item(plan[k].cmd, plan[k].idx, plan[k].amt, plan[k].typed,
                          plan[k].want);
            end
        end

        // Random part in phases. Each phase picks a new policy and search
        // count, the extremes among them, and a sender idling pattern:
        // none, heavy or moderate.
        for (ph = 0; ph < 12; ph++) begin
            write_reg(REG_FIT_POLICY, CFG_DAT_W'($urandom_range(3)));
            case (ph % 6)
                0: begin
                    blocks = 5'd16;
                end
                1: begin
                    blocks = 5'd31;
                end
                2: begin
                    blocks = 5'd1;
                end
                default: begin
                    blocks = CFG_DAT_W'($urandom_range(2, 20));
                end
            endcase
            write_reg(REG_BLOCKS_IN_USE, blocks);
            case (ph % 3)
                0: begin
                    idle_pct = 0;
                end
                1: begin
                    idle_pct = 82;
                end
                default: begin
                    idle_pct = 36;
                end
            endcase
            for (n = 0; n < 120; n++) begin
                random_item(cmd, idx, amt);
                send_item(cmd, idx, amt, 1'b0, '0);
            end
        end

        // Let the last results drain, then allow a few more cycles for any
        // strobe that should not come.
        i_start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d loads and %0d allocates (%0d granted) over %0d register writes,",
                 n_loads, n_allocs, n_granted, n_regs);
        $display("covering all fit policies, search counts from zero to saturation.");
        if (errors == 0) begin
            $display("fit_policy_block_allocator: match");
        end else begin
            $display("fit_policy_block_allocator: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/fpba_pkg.sv
hdl/fpba_ctrl.sv
hdl/fpba_datapath.sv
hdl/fit_policy_block_allocator.sv
tb/fit_policy_block_allocator_tb.sv
